/* rtl/ssap_pkg.sv */
// Package: constants, types and arithmetic helpers of the stereo allpass filter.
`timescale 1ns / 1ps
`default_nettype none
package ssap_pkg;

	localparam int MAX_DELAY  = 4096;
	localparam int CHANNELS   = 2;
	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 14;
	localparam int COEF_W     = 15;
	localparam int DELAY_W    = 13;
	localparam int CHAN_W     = 2;
	localparam int ADDR_W     = $clog2(MAX_DELAY);
	localparam int STEP_W     = $clog2(COEF_W);
	localparam int ACC_W      = SAMPLE_W + 2;
	localparam int PROD_W     = ACC_W + COEF_W;
	localparam int RND_W      = PROD_W - FRAC_W;
	localparam int WIDE_W     = RND_W + 1;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int GAIN_LIMIT = ((95 << FRAC_W) + 50) / 100;

	localparam logic signed [COEF_W-1:0] GAIN_HI = COEF_W'(GAIN_LIMIT);
	localparam logic signed [COEF_W-1:0] GAIN_LO = COEF_W'(-GAIN_LIMIT);
	localparam logic signed [COEF_W-1:0] GAIN_RESET = COEF_W'(8192);
	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(441);
	localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(MAX_DELAY);
	localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(CHANNELS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COEF_W - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DELAY - 1);

	localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-(longint'(1) << (SAMPLE_W - 1)));

	localparam logic [1:0] REG_GAIN     = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MUL_D,
		ST_UPDATE,
		ST_MUL_V,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              accept;
		logic              load_d;
		logic              step;
		logic              last;
		logic              update;
		logic              clear;
		logic [ADDR_W-1:0] raddr;
		logic [ADDR_W-1:0] waddr;
	} lane_ctrl_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [WIDE_W-1:0] w
	);
		if (w > SAT_HI) begin
			return SAT_HI[SAMPLE_W-1:0];
		end else if (w < SAT_LO) begin
			return SAT_LO[SAMPLE_W-1:0];
		end
		return w[SAMPLE_W-1:0];
	endfunction

	// floor(p / 2^F + 1/2): the dropped half bit carries in
	function automatic logic signed [RND_W-1:0] round_product(
		input logic [PROD_W-1:0] p
	);
		logic signed [RND_W-1:0] hi;
		hi = p[PROD_W-1:FRAC_W];
		return hi + RND_W'(p[FRAC_W-1]);
	endfunction

endpackage
`default_nettype wire

/* rtl/ssap_in_if.sv */
// Interface: input frame channel with two samples.
`timescale 1ns / 1ps
`default_nettype none
interface ssap_in_if;
	import ssap_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_left;
	logic signed [SAMPLE_W-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface
`default_nettype wire

/* rtl/ssap_out_if.sv */
// Interface: result frame channel with two filtered samples.
`timescale 1ns / 1ps
`default_nettype none
interface ssap_out_if;
	import ssap_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface
`default_nettype wire

/* rtl/ssap_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ssap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/ssap_lane.sv */
// One channel: delay memory, bit-serial gain multiplier and allpass arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module ssap_lane (
	input  logic                                clk,
	input  ssap_pkg::lane_ctrl_t                ctrl,
	input  logic signed [ssap_pkg::COEF_W-1:0]  gain,
	input  logic                                wr_on,
	input  logic signed [ssap_pkg::SAMPLE_W-1:0] x,
	output logic signed [ssap_pkg::SAMPLE_W-1:0] y
);
	import ssap_pkg::*;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] d_q;
	logic signed [ACC_W-1:0]    mcand_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [COEF_W-1:0]          lo_q;
	logic [COEF_W-1:0]          gsh_q;

	logic                       ram_we;
	logic [SAMPLE_W-1:0]        ram_wdata;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] d_rd;
	logic signed [ACC_W-1:0]    addend;
	logic signed [ACC_W-1:0]    sum;
	logic [PROD_W-1:0]          prod;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SAMPLE_W-1:0] v;

	ssap_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_DELAY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctrl.waddr),
		.wdata (ram_wdata),
		.raddr (ctrl.raddr),
		.rdata (ram_rdata)
	);

	assign d_rd      = ram_rdata;
	assign prod      = {acc_q, lo_q};
	assign rnd       = round_product(prod);
	assign v         = sat_sample(WIDE_W'(x_q) - WIDE_W'(rnd));
	assign y         = sat_sample(WIDE_W'(rnd) + WIDE_W'(d_q));
	assign ram_we    = ctrl.clear | (ctrl.update & wr_on);
	assign ram_wdata = ctrl.clear ? '0 : v;

	// sign bit of the gain weighs negative
	always_comb begin
		if (!gsh_q[0]) begin
			addend = '0;
		end else if (ctrl.last) begin
			addend = -mcand_q;
		end else begin
			addend = mcand_q;
		end
	end

	assign sum = acc_q + addend;

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			x_q <= x;
		end
		if (ctrl.load_d) begin
			d_q     <= d_rd;
			mcand_q <= ACC_W'(d_rd);
			acc_q   <= '0;
			lo_q    <= '0;
			gsh_q   <= gain;
		end else if (ctrl.update) begin
			mcand_q <= ACC_W'(v);
			acc_q   <= '0;
			lo_q    <= '0;
			gsh_q   <= gain;
		end else if (ctrl.step) begin
			acc_q <= sum >>> 1;
			lo_q  <= {sum[0], lo_q[COEF_W-1:1]};
			gsh_q <= gsh_q >> 1;
		end
	end
endmodule
`default_nettype wire

/* rtl/stereo_schroeder_allpass.sv */
// Top level: stereo Schroeder allpass filter with APB register port.
// Each accepted frame runs both channels side by side and yields one result frame;
// the next frame is taken in the cycle after the result is loaded, so a new frame is
// accepted only once the last one is finished. The pace is set by the two bit-serial
// gain multiplications per channel (g*d, then g*v), each taking one gain bit per cycle
// over all 15 gain bits. A finished result waits in an output register while the next
// frame is accepted. After reset the delay memories are swept to zero, one address per
// cycle, and no frame is accepted during the sweep; register writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module stereo_schroeder_allpass (
	input  logic                         clk,
	input  logic                         arst_n,
	ssap_in_if.sink                      samples,
	ssap_out_if.source                   results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssap_pkg::PADDR_W-1:0] paddr,
	input  logic [ssap_pkg::PDATA_W-1:0] pwdata,
	output logic [ssap_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import ssap_pkg::*;

	state_t                     state_q;
	state_t                     state_nxt;
	logic [STEP_W-1:0]          cnt_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [ADDR_W-1:0]          wp_q;
	logic signed [COEF_W-1:0]   gain_q;
	logic [DELAY_W-1:0]         delay_q;
	logic [CHAN_W-1:0]          chan_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_left_q;
	logic signed [SAMPLE_W-1:0] out_right_q;

	logic                       in_ready;
	logic                       accept;
	logic                       slot_free;
	logic                       take;
	logic                       mul_last;
	logic                       right_on;
	logic [1:0]                 reg_idx;
	logic signed [COEF_W-1:0]   g_eff;
	logic [DELAY_W-1:0]         dl_eff;
	logic signed [SAMPLE_W-1:0] y_left;
	logic signed [SAMPLE_W-1:0] y_right;
	lane_ctrl_t                 ctrl;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[PADDR_W-1:2];
	assign right_on = chan_q[1];

	always_comb begin
		if (gain_q > GAIN_HI) begin
			g_eff = GAIN_HI;
		end else if (gain_q < GAIN_LO) begin
			g_eff = GAIN_LO;
		end else begin
			g_eff = gain_q;
		end
	end

	always_comb begin
		if (delay_q == '0) begin
			dl_eff = DELAY_W'(1);
		end else if (delay_q > DELAY_MAX) begin
			dl_eff = DELAY_MAX;
		end else begin
			dl_eff = delay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RESET;
			delay_q <= DELAY_RESET;
			chan_q  <= CHAN_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_GAIN:     gain_q  <= pwdata[COEF_W-1:0];
				REG_DELAY:    delay_q <= pwdata[DELAY_W-1:0];
				REG_CHANNELS: chan_q  <= pwdata[CHAN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:     prdata = PDATA_W'(gain_q);
			REG_DELAY:    prdata = PDATA_W'(delay_q);
			REG_CHANNELS: prdata = PDATA_W'(chan_q);
			default:      prdata = '0;
		endcase
	end

	assign accept    = samples.valid & in_ready;
	assign slot_free = ~out_valid_q | results.ready;
	assign take      = (state_q == ST_FINISH) & slot_free;
	assign mul_last  = (cnt_q == LAST_STEP);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == LAST_ADDR) state_nxt = ST_IDLE;
			ST_IDLE:   if (accept) state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_MUL_D;
			ST_MUL_D:  if (mul_last) state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_MUL_V;
			ST_MUL_V:  if (mul_last) state_nxt = ST_FINISH;
			ST_FINISH: if (slot_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		ctrl.accept = accept;
		ctrl.load_d = (state_q == ST_READ);
		ctrl.step   = (state_q == ST_MUL_D) | (state_q == ST_MUL_V);
		ctrl.last   = mul_last;
		ctrl.update = (state_q == ST_UPDATE);
		ctrl.clear  = (state_q == ST_CLEAR);
		ctrl.raddr  = wp_q - dl_eff[ADDR_W-1:0];
		ctrl.waddr  = (state_q == ST_CLEAR) ? clr_q : wp_q;
	end

	assign samples.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
			wp_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.step && !mul_last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (ctrl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (take) begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	ssap_lane u_left (
		.clk   (clk),
		.ctrl  (ctrl),
		.gain  (g_eff),
		.wr_on (1'b1),
		.x     (samples.sample_left),
		.y     (y_left)
	);

	ssap_lane u_right (
		.clk   (clk),
		.ctrl  (ctrl),
		.gain  (g_eff),
		.wr_on (right_on),
		.x     (samples.sample_right),
		.y     (y_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_left_q  <= y_left;
			out_right_q <= right_on ? y_right : '0;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_left  = out_left_q;
	assign results.out_right = out_right_q;
endmodule
`default_nettype wire

/* rtl/ssap_checker.sv */
// Checker: port-level assertions for the stereo allpass filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ssap_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ssap_pkg::SAMPLE_W-1:0] out_left,
	input logic [ssap_pkg::SAMPLE_W-1:0] out_right
);
	import ssap_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready after item accepted");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared right after acceptance");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("block not ready when result appears");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_left) && $stable(out_right)))
		else $error("stalled result changed");
endmodule

bind stereo_schroeder_allpass ssap_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_left  (results.out_left),
	.out_right (results.out_right)
);
`default_nettype wire

/* dv/tb.sv */
// Testbench for the stereo Schroeder allpass filter: random frames and settings vs. a local model.
`timescale 1ns / 1ps
module tb;
	import ssap_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam longint SMP_TOP = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SMP_BOTTOM = -SMP_TOP - 1;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = SAMPLE_W'(SMP_TOP);
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = SAMPLE_W'(SMP_BOTTOM);
	localparam int RANDOM_FRAMES = 950;
	localparam int FINAL_FRAMES = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ssap_in_if samples ();
	ssap_out_if results ();

	stereo_schroeder_allpass dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// filter model state
	logic signed [COEF_W-1:0] gain_reg = GAIN_RESET;
	logic [DELAY_W-1:0] delay_reg = DELAY_RESET;
	logic [CHAN_W-1:0] chan_reg = CHAN_RESET;
	logic signed [SAMPLE_W-1:0] taps [CHANNELS][MAX_DELAY];
	int wr_pos = 0;

	frame_t frames_to_send[$];
	frame_t filtered_due[$];
	frame_t outgoing;
	frame_t due;
	int frames_queued = 0;
	int frames_taken = 0;
	int frames_checked = 0;
	int errors = 0;
	int send_gap = 0;
	int ready_hold = 0;
	int quiet_cycles = 0;
	bit long_hold_done = 1'b0;
	bit calm = 1'b0;

	function automatic longint scaled(input longint p);
		return (p + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip(input longint w);
		if (w > SMP_TOP) begin
			return SMP_MAX;
		end else if (w < SMP_BOTTOM) begin
			return SMP_MIN;
		end
		return SAMPLE_W'(w);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] lane_step(input int c, input int rd,
			input longint x, input longint g);
		longint d;
		longint v;
		d = taps[c][rd];
		v = clip(x - scaled(g * d));
		taps[c][wr_pos] = SAMPLE_W'(v);
		return clip(scaled(g * v) + d);
	endfunction

	function automatic frame_t filter_frame(input logic signed [SAMPLE_W-1:0] xl,
			input logic signed [SAMPLE_W-1:0] xr);
		longint g;
		int dl;
		int ch;
		int rd;
		frame_t r;
		g = gain_reg;
		if (g > GAIN_LIMIT) g = GAIN_LIMIT;
		if (g < -GAIN_LIMIT) g = -GAIN_LIMIT;
		dl = delay_reg;
		if (dl < 1) dl = 1;
		if (dl > MAX_DELAY) dl = MAX_DELAY;
		ch = chan_reg;
		if (ch < 1) ch = 1;
		if (ch > CHANNELS) ch = CHANNELS;
		rd = (wr_pos + MAX_DELAY - dl) % MAX_DELAY;
		r.left = lane_step(0, rd, xl, g);
		r.right = (ch >= 2) ? lane_step(1, rd, xr, g) : '0;
		wr_pos = (wr_pos + 1) % MAX_DELAY;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: begin
				return SMP_MAX;
			end
			1: begin
				return SMP_MIN;
			end
			2: begin
				return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
			end
			3: begin
				return SMP_MAX - SAMPLE_W'($urandom_range(0, 15));
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		frame_t f;
		f.left = l;
		f.right = r;
		frames_to_send.push_back(f);
		frames_queued++;
	endtask

	task automatic wait_drained();
		while (frames_taken != frames_queued || filtered_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// field bits carry the value, the bits above it are junk
	task automatic write_reg(input logic [1:0] idx, input int value);
		logic [PDATA_W-1:0] data;
		data = $urandom;
		case (idx)
			REG_GAIN: begin
				data[COEF_W-1:0] = COEF_W'(value);
			end
			REG_DELAY: begin
				data[DELAY_W-1:0] = DELAY_W'(value);
			end
			REG_CHANNELS: begin
				data[CHAN_W-1:0] = CHAN_W'(value);
			end
			default: begin
				data = PDATA_W'(value);
			end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN: begin
				gain_reg = data[COEF_W-1:0];
			end
			REG_DELAY: begin
				delay_reg = data[DELAY_W-1:0];
			end
			REG_CHANNELS: begin
				chan_reg = data[CHAN_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic random_setup();
		int g;
		int d;
		case ($urandom_range(0, 5))
			0: g = GAIN_LIMIT;
			1: g = -GAIN_LIMIT;
			2: g = 16383;
			3: g = -16384;
			4: g = 0;
			default: g = int'($urandom_range(0, 32767)) - 16384;
		endcase
		case ($urandom_range(0, 6))
			0: d = 0;
			1: d = $urandom_range(1, 3);
			2: d = $urandom_range(1, 64);
			3: d = MAX_DELAY;
			4: d = $urandom_range(MAX_DELAY + 1, 8191);
			default: d = $urandom_range(1, MAX_DELAY);
		endcase
		if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
		write_reg(REG_GAIN, g);
		write_reg(REG_DELAY, d);
		write_reg(REG_CHANNELS, $urandom_range(0, 3));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples.valid <= 1'b0;
		end else if (!samples.valid || samples.ready) begin
			if (samples.valid) begin
				filtered_due.push_back(filter_frame(samples.sample_left, samples.sample_right));
				frames_taken++;
			end
			if (send_gap > 0) begin
				samples.valid <= 1'b0;
				send_gap--;
			end else if (!calm && frames_to_send.size() != 0 && $urandom_range(0, 7) == 0) begin
				samples.valid <= 1'b0;
				send_gap = $urandom_range(0, 3);
			end else if (frames_to_send.size() != 0) begin
				outgoing = frames_to_send.pop_front();
				samples.valid <= 1'b1;
				samples.sample_left <= outgoing.left;
				samples.sample_right <= outgoing.right;
			end else begin
				samples.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (filtered_due.size() == 0) begin
					$error("result item with no frame pending");
					errors++;
				end else begin
					due = filtered_due.pop_front();
					if (results.out_left !== due.left) begin
						$error("out_left expected %0d got %0d", due.left, results.out_left);
						errors++;
					end
					if (results.out_right !== due.right) begin
						$error("out_right expected %0d got %0d", due.right, results.out_right);
						errors++;
					end
				end
				frames_checked++;
			end
			// hold off long enough to back up the input
			if (frames_checked >= 300 && !long_hold_done && frames_to_send.size() > 8) begin
				long_hold_done = 1'b1;
				ready_hold = 400;
			end
			if (ready_hold > 0) begin
				results.ready <= 1'b0;
				ready_hold--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				ready_hold = $urandom_range(0, 3);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (results.valid && results.ready)
					|| (psel && penable && pwrite && pready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int n;
		int sent;
		samples.valid = 1'b0;
		samples.sample_left = '0;
		samples.sample_right = '0;
		results.ready = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int a = 0; a < MAX_DELAY; a++) begin
				taps[c][a] = '0;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(0, 0);
		send_frame(-1, 1);
		wait_drained();

		// gain above range, shortest delay, channel count three
		write_reg(REG_GAIN, 16383);
		write_reg(REG_DELAY, 1);
		write_reg(REG_CHANNELS, 3);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(SMP_MIN, SMP_MAX);
		send_frame(SMP_MAX, SMP_MAX);
		send_frame(SMP_MAX, SMP_MAX);
		send_frame(SMP_MIN, SMP_MIN);
		send_frame(24'sh555555, 24'shAAAAAA);
		send_frame(24'shAAAAAA, 24'sh555555);
		send_frame(1, -1);
		wait_drained();

		// gain below range, delay zero, channel count zero, spare register ignored
		write_reg(REG_GAIN, -16384);
		write_reg(REG_DELAY, 0);
		write_reg(REG_CHANNELS, 0);
		write_reg(REG_SPARE, 0);
		send_frame(SMP_MAX, SMP_MAX);
		send_frame(SMP_MIN, SMP_MIN);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(0, SMP_MAX);
		send_frame(SMP_MIN, -1);
		wait_drained();

		// delay above range, zero gain
		write_reg(REG_GAIN, 0);
		write_reg(REG_DELAY, 8191);
		write_reg(REG_CHANNELS, 2);
		send_frame(SMP_MAX, SMP_MIN);
		send_frame(-1, -1);
		send_frame(SMP_MIN, SMP_MAX);
		wait_drained();

		sent = 0;
		while (sent < RANDOM_FRAMES) begin
			random_setup();
			n = $urandom_range(30, 150);
			repeat (n) send_frame(pick_sample(), pick_sample());
			sent += n;
			wait_drained();
		end

		// full delay, back to back with no idling
		calm = 1'b1;
		write_reg(REG_GAIN, $urandom_range(0, 1) ? GAIN_LIMIT : -GAIN_LIMIT);
		write_reg(REG_DELAY, MAX_DELAY);
		write_reg(REG_CHANNELS, 2);
		repeat (FINAL_FRAMES) send_frame(pick_sample(), pick_sample());
		wait_drained();
		repeat (40) @(posedge clk);

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

/* stereo_schroeder_allpass.f */
rtl/ssap_pkg.sv
rtl/ssap_in_if.sv
rtl/ssap_out_if.sv
rtl/ssap_ram.sv
rtl/ssap_lane.sv
rtl/stereo_schroeder_allpass.sv
rtl/ssap_checker.sv
dv/tb.sv
